>>> design/ampn_pkg.sv
// Package: constants, widths and state encoding of the peak-normalizing audio mixer.
package ampn_pkg;

   localparam int FRAME_SLOTS    = 64;
   localparam int MAX_WRITERS    = 16;
   localparam int PCM_FULL_SCALE = 32767;

   localparam int SLOT_W   = 6;
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 20;
   localparam int CNT_W    = 5;
   localparam int Q_W      = 15;
   localparam int DIV_CNT_W = 4;

   // Command codes carried by req_cmd.
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_PEAK,
      ST_PEAK_END,
      ST_OUT_RD,
      ST_OUT_CALC,
      ST_DIV,
      ST_OUT_SEND
   } state_type;

endpackage

>>> design/audio_mixer_peak_normalize.sv
// Top level: frame mixer with a slot-sum memory, peak search and peak normalization.
//
// Usage:
//  - Request channel (req_valid / req_stall): an item with req_cmd = 0 adds req_sample
//    into the saturating 20-bit sum of slot req_slot; req_writer_done = 1 counts one
//    finished writer. An item with req_cmd = 1 closes the frame and emits it.
//  - Response channel (rsp_valid / rsp_stall): one item per slot, slots 0 upward,
//    rsp_last high on the final slot. Add items produce no response.
//  - An add does one memory read, then the write-back of the new sum, as a
//    read-modify-write of the sum memory.
//  - An emit walks the memory twice: once to find the peak, then once to read and
//    send each slot, through the serial divider for each slot when scaling
//    applies (more than one writer and peak above 32767).
//  - req_stall is high whenever an item is in flight; a new item is taken while the
//    last response item still waits in the output register.
//  - When the receiver stalls, the output register holds its item and the emit
//    sequence waits before loading the next slot.
//  - Reset (synchronous, active high) clears the writer count and the per-slot valid
//    bits, so every sum reads as zero; the same happens at the end of each emit.
module audio_mixer_peak_normalize (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic [ampn_pkg::SLOT_W-1:0]           req_slot,
   input  logic signed [ampn_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  req_writer_done,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ampn_pkg::SAMPLE_W-1:0]  rsp_mixed_sample,
   output logic [ampn_pkg::SLOT_W-1:0]           rsp_out_slot,
   output logic                                  rsp_last
);

   localparam int SUM_W  = ampn_pkg::SUM_W;
   localparam int SLOT_W = ampn_pkg::SLOT_W;
   localparam int SMP_W  = ampn_pkg::SAMPLE_W;
   localparam int Q_W    = ampn_pkg::Q_W;
   localparam int DVD_W  = SUM_W + Q_W;

   // Saturate a 21-bit sum to the signed 20-bit range.
   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
      logic signed [SUM_W:0] hi;
      logic signed [SUM_W:0] lo;
      hi = (SUM_W+1)'(signed'({1'b0, {(SUM_W-1){1'b1}}}));
      lo = -hi - (SUM_W+1)'(1);
      if (v > hi) begin
         return SUM_W'(hi);
      end else if (v < lo) begin
         return SUM_W'(lo);
      end
      return SUM_W'(v);
   endfunction

   // Saturate a 20-bit sum to the signed 16-bit range.
   function automatic logic signed [SMP_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(ampn_pkg::PCM_FULL_SCALE);
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         return SMP_W'(hi);
      end else if (v < lo) begin
         return SMP_W'(lo);
      end
      return SMP_W'(v);
   endfunction

   // Slot-sum memory and per-slot valid bits.
   logic signed [SUM_W-1:0]        sum_mem [ampn_pkg::FRAME_SLOTS];
   logic [ampn_pkg::FRAME_SLOTS-1:0] slot_vld_ff;
   logic signed [SUM_W-1:0]        mem_q_ff;
   logic                           rd_vld_ff;

   logic                           mem_re;
   logic [SLOT_W-1:0]              mem_raddr;
   logic                           mem_we;
   logic [SLOT_W-1:0]              mem_waddr;
   logic signed [SUM_W-1:0]        mem_wdata;
   logic                           vld_clr;

   ampn_pkg::state_type            state_ff, state_in;

   logic [SLOT_W-1:0]              idx_ff, idx_in;
   logic [SLOT_W-1:0]              add_slot_ff, add_slot_in;
   logic signed [SMP_W-1:0]        add_sample_ff, add_sample_in;
   logic                           add_ok_ff, add_ok_in;
   logic [ampn_pkg::CNT_W-1:0]     wcnt_ff, wcnt_in;
   logic [SUM_W-1:0]               peak_ff, peak_in;
   logic                           pk_dv_ff, pk_dv_in;
   logic [SUM_W:0]                 rem_ff, rem_in;
   logic [Q_W-1:0]                 dvd_ff, dvd_in;
   logic [Q_W-1:0]                 q_ff, q_in;
   logic [ampn_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           neg_ff, neg_in;
   logic signed [SMP_W-1:0]        res_ff, res_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SMP_W-1:0]        rsp_sample_ff, rsp_sample_in;
   logic [SLOT_W-1:0]              rsp_slot_ff, rsp_slot_in;
   logic                           rsp_last_ff, rsp_last_in;

   // Derived values.
   logic signed [SUM_W-1:0]        sum_rd;
   logic                           sum_neg;
   logic [SUM_W-1:0]               sum_mag;
   logic [DVD_W-1:0]               dividend;
   logic                           scale;
   logic                           idx_last;
   logic                           out_free;
   logic [SUM_W:0]                 trial;
   logic                           trial_ge;
   logic signed [SMP_W-1:0]        q_signed;

   assign sum_rd   = rd_vld_ff ? mem_q_ff : '0;
   assign sum_neg  = sum_rd[SUM_W-1];
   assign sum_mag  = sum_neg ? SUM_W'(-sum_rd) : SUM_W'(sum_rd);
   // mag * 32767 as (mag << 15) - mag
   assign dividend = {sum_mag, {Q_W{1'b0}}} - DVD_W'(sum_mag);
   assign scale    = (wcnt_ff > ampn_pkg::CNT_W'(1))
                     && (peak_ff > SUM_W'(ampn_pkg::PCM_FULL_SCALE));
   assign idx_last = idx_ff == SLOT_W'(ampn_pkg::FRAME_SLOTS - 1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign trial    = {rem_ff[SUM_W-1:0], dvd_ff[Q_W-1]};
   assign trial_ge = trial >= {1'b0, peak_ff};
   assign q_signed = neg_ff ? -signed'({1'b0, q_ff}) : signed'({1'b0, q_ff});

   assign req_stall        = state_ff != ampn_pkg::ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_sample_ff;
   assign rsp_out_slot     = rsp_slot_ff;
   assign rsp_last         = rsp_last_ff;

   // Memory: synchronous read, one write port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff  <= sum_mem[mem_raddr];
         rd_vld_ff <= slot_vld_ff[mem_raddr];
      end
   end

   // Valid bits: an entry that was never written since the last clear reads as zero.
   always_ff @(posedge clock) begin
      if (reset || vld_clr) begin
         slot_vld_ff <= '0;
      end else if (mem_we) begin
         slot_vld_ff[mem_waddr] <= 1'b1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ampn_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_cmd == ampn_pkg::CMD_EMIT) ? ampn_pkg::ST_PEAK
                                                          : ampn_pkg::ST_ADD_WR;
            end
         end
         ampn_pkg::ST_ADD_WR:   state_in = ampn_pkg::ST_IDLE;
         ampn_pkg::ST_PEAK: begin
            if (idx_last) begin
               state_in = ampn_pkg::ST_PEAK_END;
            end
         end
         ampn_pkg::ST_PEAK_END: state_in = ampn_pkg::ST_OUT_RD;
         ampn_pkg::ST_OUT_RD:   state_in = ampn_pkg::ST_OUT_CALC;
         ampn_pkg::ST_OUT_CALC: begin
            state_in = scale ? ampn_pkg::ST_DIV : ampn_pkg::ST_OUT_SEND;
         end
         ampn_pkg::ST_DIV: begin
            if (cnt_ff == ampn_pkg::DIV_CNT_W'(Q_W - 1)) begin
               state_in = ampn_pkg::ST_OUT_SEND;
            end
         end
         ampn_pkg::ST_OUT_SEND: begin
            if (out_free) begin
               state_in = idx_last ? ampn_pkg::ST_IDLE : ampn_pkg::ST_OUT_RD;
            end
         end
         default: state_in = ampn_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      mem_re        = 1'b0;
      mem_raddr     = idx_ff;
      mem_we        = 1'b0;
      mem_waddr     = add_slot_ff;
      mem_wdata     = sat_sum((SUM_W+1)'(sum_rd) + (SUM_W+1)'(add_sample_ff));
      vld_clr       = 1'b0;
      idx_in        = idx_ff;
      add_slot_in   = add_slot_ff;
      add_sample_in = add_sample_ff;
      add_ok_in     = add_ok_ff;
      wcnt_in       = wcnt_ff;
      peak_in       = peak_ff;
      pk_dv_in      = state_ff == ampn_pkg::ST_PEAK;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      q_in          = q_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;

      // Fold the returning read into the running peak.
      if (pk_dv_ff && (sum_mag > peak_ff)) begin
         peak_in = sum_mag;
      end

      case (state_ff)
         ampn_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == ampn_pkg::CMD_ADD) begin
                  mem_re        = 1'b1;
                  mem_raddr     = req_slot;
                  add_slot_in   = req_slot;
                  add_sample_in = req_sample;
                  add_ok_in     = {1'b0, req_slot} < (SLOT_W+1)'(ampn_pkg::FRAME_SLOTS);
                  if (req_writer_done
                      && (wcnt_ff < ampn_pkg::CNT_W'(ampn_pkg::MAX_WRITERS))) begin
                     wcnt_in = wcnt_ff + ampn_pkg::CNT_W'(1);
                  end
               end else begin
                  idx_in  = '0;
                  peak_in = '0;
               end
            end
         end
         ampn_pkg::ST_ADD_WR: begin
            mem_we = add_ok_ff;
         end
         ampn_pkg::ST_PEAK: begin
            mem_re = 1'b1;
            idx_in = idx_last ? '0 : idx_ff + SLOT_W'(1);
         end
         ampn_pkg::ST_PEAK_END: begin
            // last read folds in through the peak update above
         end
         ampn_pkg::ST_OUT_RD: begin
            mem_re = 1'b1;
         end
         ampn_pkg::ST_OUT_CALC: begin
            if (scale) begin
               rem_in = (SUM_W+1)'(dividend[DVD_W-1:Q_W]);
               dvd_in = dividend[Q_W-1:0];
               q_in   = '0;
               cnt_in = '0;
               neg_in = sum_neg;
            end else begin
               res_in = sat16(sum_rd);
            end
         end
         ampn_pkg::ST_DIV: begin
            rem_in = trial_ge ? trial - {1'b0, peak_ff} : trial;
            q_in   = {q_ff[Q_W-2:0], trial_ge};
            dvd_in = {dvd_ff[Q_W-2:0], 1'b0};
            cnt_in = cnt_ff + ampn_pkg::DIV_CNT_W'(1);
         end
         ampn_pkg::ST_OUT_SEND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = scale ? q_signed : res_ff;
               rsp_slot_in   = idx_ff;
               rsp_last_in   = idx_last;
               if (idx_last) begin
                  // drop the frame: clear sums and writer count
                  vld_clr = 1'b1;
                  wcnt_in = '0;
                  idx_in  = '0;
               end else begin
                  idx_in = idx_ff + SLOT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ampn_pkg::ST_IDLE;
         wcnt_ff      <= '0;
         pk_dv_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         wcnt_ff      <= wcnt_in;
         pk_dv_ff     <= pk_dv_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      add_slot_ff   <= add_slot_in;
      add_sample_ff <= add_sample_in;
      add_ok_ff     <= add_ok_in;
      peak_ff       <= peak_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
      q_ff          <= q_in;
      cnt_ff        <= cnt_in;
      neg_ff        <= neg_in;
      res_ff        <= res_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

>>> dv/audio_mixer_peak_normalize_test.sv
// Self-checking testbench for the peak-normalizing audio frame mixer.
module audio_mixer_peak_normalize_test;

   localparam int SUM_W          = ampn_pkg::SUM_W;
   localparam int SAMPLE_W       = ampn_pkg::SAMPLE_W;
   localparam int SLOT_W         = ampn_pkg::SLOT_W;
   localparam int CNT_W          = ampn_pkg::CNT_W;
   localparam int FRAME_SLOTS    = ampn_pkg::FRAME_SLOTS;
   localparam int MAX_WRITERS    = ampn_pkg::MAX_WRITERS;
   localparam int PCM_FULL_SCALE = ampn_pkg::PCM_FULL_SCALE;

   // Operation codes carried by req_cmd.
   localparam logic CMD_ADD  = ampn_pkg::CMD_ADD;
   localparam logic CMD_EMIT = ampn_pkg::CMD_EMIT;

   localparam int SUM_TOP       = (1 << (SUM_W - 1)) - 1;
   localparam int SUM_BOTTOM    = -(1 << (SUM_W - 1));
   localparam int PLAN_ROWS     = 21;
   localparam int RANDOM_ITEMS  = 190;
   localparam int CHOKE_AT      = 500;   // result count at which the receiver chokes
   localparam int CHOKE_CYCLES  = 300;
   localparam int PAUSE_FRAME   = 6;     // random frame before which the sender drains
   localparam int SETTLE_CYCLES = 100;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mixed;
      logic [SLOT_W-1:0]   slot;
      logic                last;
   } mixed_exp_type;

   // One directed row: the item itself plus an optional pinned output value
   // for one slot of the frame that an emit row gives out.
   typedef struct packed {
      logic                cmd;
      logic [SLOT_W-1:0]   slot;
      logic [SAMPLE_W-1:0] sample;
      logic                done;
      logic                pinned;
      logic [SLOT_W-1:0]   pin_slot;
      logic [SAMPLE_W-1:0] pin_val;
   } drive_row_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_cmd;
   logic [SLOT_W-1:0]          req_slot;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_writer_done;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_mixed_sample;
   logic [SLOT_W-1:0]          rsp_out_slot;
   logic                       rsp_last;

   // Predictor state: the frame sums and the finished-writer count.
   logic signed [SUM_W-1:0] slot_sum [FRAME_SLOTS];
   logic [CNT_W-1:0]        writers;
   mixed_exp_type           mixed_due [$];

   drive_row_type plan [PLAN_ROWS];
   int         items_offered = 0;
   int         errors = 0;
   bit         sender_calm = 1'b0;

   audio_mixer_peak_normalize dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_slot         (req_slot),
      .req_sample       (req_sample),
      .req_writer_done  (req_writer_done),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mixed_sample (rsp_mixed_sample),
      .rsp_out_slot     (rsp_out_slot),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the mixer model by one accepted item. An add folds the sample into
   // its slot with saturation and may count a writer; an emit queues the whole
   // frame, scaled against the peak when several writers pushed it past 16 bits.
   function automatic void mix_frame_step(logic cmd, logic [SLOT_W-1:0] slot,
                                          logic [SAMPLE_W-1:0] smp, logic done);
      int            acc;
      int            peak;
      int            mag;
      int            i;
      longint        q;
      bit            scale;
      mixed_exp_type e;
      if (cmd == CMD_ADD) begin
         acc = int'(slot_sum[slot]) + int'($signed(smp));
         if (acc > SUM_TOP) acc = SUM_TOP;
         else if (acc < SUM_BOTTOM) acc = SUM_BOTTOM;
         slot_sum[slot] = acc[SUM_W-1:0];
         if (done && writers < MAX_WRITERS) writers = writers + 1'b1;
      end else begin
         peak = 0;
         for (i = 0; i < FRAME_SLOTS; i++) begin
            mag = int'(slot_sum[i]);
            if (mag < 0) mag = -mag;
            if (mag > peak) peak = mag;
         end
         scale = (writers > 1) && (peak > PCM_FULL_SCALE);
         for (i = 0; i < FRAME_SLOTS; i++) begin
            acc = int'(slot_sum[i]);
            if (scale) begin
               // Scale the magnitude, then restore the sign: truncates toward zero.
               q = (longint'(acc < 0 ? -acc : acc) * PCM_FULL_SCALE) / peak;
               if (acc < 0) q = -q;
               acc = int'(q);
            end else if (acc > PCM_FULL_SCALE) begin
               acc = PCM_FULL_SCALE;
            end else if (acc < -PCM_FULL_SCALE - 1) begin
               acc = -PCM_FULL_SCALE - 1;
            end
            e.mixed = acc[SAMPLE_W-1:0];
            e.slot  = i[SLOT_W-1:0];
            e.last  = (i == FRAME_SLOTS - 1);
            mixed_due.push_back(e);
            slot_sum[i] = '0;
         end
         writers = '0;
      end
   endfunction

   // Mix of extremes, values near zero and anything at all.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [31:0] r;
      case ($urandom_range(0, 3))
         0: r = $urandom_range(0, 1) ? 32'h7FFF : 32'h8000;
         1: r = $urandom_range(0, 128) - 64;
         default: r = $urandom;
      endcase
      return r[SAMPLE_W-1:0];
   endfunction

   // Offer one item: idle a random number of cycles (none when calm), hold the
   // item until the block takes it, then advance the model at that edge. Valid
   // stays high across back-to-back items so it is never dropped and re-raised
   // in one step.
   task automatic offer(input logic cmd, input logic [SLOT_W-1:0] slot,
                        input logic [SAMPLE_W-1:0] smp, input logic done);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_slot        <= slot;
      req_sample      <= smp;
      req_writer_done <= done;
      do @(posedge clock); while (req_stall);
      mix_frame_step(cmd, slot, smp, done);
      items_offered++;
   endtask

   // Sender: reset, the directed table, then random frames, then the drain.
   initial begin : send_side
      int               k;
      int               idx;
      int               frame_no;
      int               nwriters;
      int               nadds;
      int               w;
      int               a;
      logic [31:0]      r;
      logic [SLOT_W-1:0] base;
      logic [SLOT_W-1:0] slot;
      logic             positive;
      mixed_exp_type    e;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_ADD;
      req_slot        = '0;
      req_sample      = '0;
      req_writer_done = 1'b0;
      for (k = 0; k < FRAME_SLOTS; k++) slot_sum[k] = '0;
      writers = '0;

      // Directed rows. Pinned values are the ones visible without arithmetic:
      // an empty frame, single-writer extremes, a two-writer peak of exactly 16
      // bits (no scaling), and peaks over it on either sign.
      plan[0]  = '{CMD_EMIT, 6'd63, 16'h8000, 1'b1, 1'b1, 6'd0,  16'h0000};
      plan[1]  = '{CMD_ADD,  6'd0,  16'h7FFF, 1'b0, 1'b0, 6'd0,  16'h0000};
      plan[2]  = '{CMD_ADD,  6'd63, 16'h8000, 1'b1, 1'b0, 6'd0,  16'h0000};
      plan[3]  = '{CMD_EMIT, 6'd0,  16'h0000, 1'b0, 1'b1, 6'd63, 16'h8000};
      plan[4]  = '{CMD_ADD,  6'd5,  16'h7FFF, 1'b0, 1'b0, 6'd0,  16'h0000};
      plan[5]  = '{CMD_ADD,  6'd5,  16'h7FFF, 1'b1, 1'b0, 6'd0,  16'h0000};
      plan[6]  = '{CMD_EMIT, 6'd0,  16'h0000, 1'b0, 1'b1, 6'd5,  16'h7FFF};
      plan[7]  = '{CMD_ADD,  6'd5,  16'h7FFF, 1'b1, 1'b0, 6'd0,  16'h0000};
      plan[8]  = '{CMD_ADD,  6'd5,  16'h7FFF, 1'b1, 1'b0, 6'd0,  16'h0000};
      plan[9]  = '{CMD_ADD,  6'd6,  16'h8000, 1'b0, 1'b0, 6'd0,  16'h0000};
      plan[10] = '{CMD_EMIT, 6'd12, 16'h7FFF, 1'b1, 1'b1, 6'd5,  16'h7FFF};
      plan[11] = '{CMD_ADD,  6'd1,  16'h8000, 1'b1, 1'b0, 6'd0,  16'h0000};
      plan[12] = '{CMD_ADD,  6'd1,  16'h8000, 1'b1, 1'b0, 6'd0,  16'h0000};
      plan[13] = '{CMD_ADD,  6'd2,  16'h0001, 1'b0, 1'b0, 6'd0,  16'h0000};
      plan[14] = '{CMD_EMIT, 6'd42, 16'h5555, 1'b0, 1'b1, 6'd1,  16'h8001};
      plan[15] = '{CMD_ADD,  6'd3,  16'h7FFF, 1'b1, 1'b0, 6'd0,  16'h0000};
      plan[16] = '{CMD_ADD,  6'd4,  16'hFFFF, 1'b1, 1'b0, 6'd0,  16'h0000};
      plan[17] = '{CMD_EMIT, 6'd21, 16'hAAAA, 1'b1, 1'b1, 6'd3,  16'h7FFF};
      plan[18] = '{CMD_ADD,  6'd7,  16'h8000, 1'b1, 1'b0, 6'd0,  16'h0000};
      plan[19] = '{CMD_ADD,  6'd8,  16'h7FFF, 1'b1, 1'b0, 6'd0,  16'h0000};
      plan[20] = '{CMD_EMIT, 6'd0,  16'h0000, 1'b0, 1'b1, 6'd7,  16'h8001};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < PLAN_ROWS; k++) begin
         offer(plan[k].cmd, plan[k].slot, plan[k].sample, plan[k].done);
         // Overwrite the model's value for the pinned slot: the frame just
         // queued is the tail of the queue, and nothing of it has come back yet.
         if (plan[k].cmd == CMD_EMIT && plan[k].pinned) begin
            idx = mixed_due.size() - FRAME_SLOTS + int'(plan[k].pin_slot);
            e = mixed_due[idx];
            e.mixed = plan[k].pin_val;
            mixed_due[idx] = e;
         end
      end

      // Random frames: mostly well-formed (writers add, each marks done, then
      // emit), some saturating stress frames, some loose noise.
      frame_no = 0;
      while (items_offered < PLAN_ROWS + RANDOM_ITEMS) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         if (frame_no == PAUSE_FRAME) begin
            // Hold off until every queued result has come back.
            req_valid <= 1'b0;
            while (mixed_due.size() != 0) @(posedge clock);
         end
         case ($urandom_range(0, 9))
            0: begin
               // Hammer one slot with one extreme from more writers than the
               // counter holds: both the sum and the count saturate.
               slot     = SLOT_W'($urandom_range(0, FRAME_SLOTS - 1));
               positive = 1'($urandom_range(0, 1));
               nadds    = $urandom_range(17, 20);
               for (a = 0; a < nadds; a++)
                  offer(CMD_ADD, slot, positive ? 16'h7FFF : 16'h8000, 1'b1);
               offer(CMD_EMIT, SLOT_W'($urandom_range(0, 63)), pick_sample(),
                     1'($urandom_range(0, 1)));
            end
            1: begin
               // Noise: loose adds with random marks, now and then an emit.
               nadds = $urandom_range(2, 6);
               for (a = 0; a < nadds; a++)
                  offer(($urandom_range(0, 3) == 0) ? CMD_EMIT : CMD_ADD,
                        SLOT_W'($urandom_range(0, 63)), pick_sample(),
                        1'($urandom_range(0, 1)));
            end
            default: begin
               nwriters = $urandom_range(1, 4);
               base     = SLOT_W'($urandom_range(0, FRAME_SLOTS - 1));
               for (w = 0; w < nwriters; w++) begin
                  nadds = $urandom_range(1, 5);
                  for (a = 0; a < nadds; a++) begin
                     // Keep most adds on a few neighboring slots so sums pile up.
                     if ($urandom_range(0, 3) == 0) begin
                        slot = SLOT_W'($urandom_range(0, FRAME_SLOTS - 1));
                     end else begin
                        r    = $urandom_range(0, 3);
                        slot = base + r[SLOT_W-1:0];
                     end
                     offer(CMD_ADD, slot, pick_sample(), a == nadds - 1);
                  end
               end
               offer(CMD_EMIT, SLOT_W'($urandom_range(0, 63)), pick_sample(),
                     1'($urandom_range(0, 1)));
            end
         endcase
         frame_no++;
      end
      req_valid <= 1'b0;

      while (mixed_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Receiver: stall a random number of cycles before each result (none while
   // calm), choke once for a long stretch, and check every result taken.
   initial begin : take_side
      int            hold;
      int            taken;
      bit            rsp_calm;
      mixed_exp_type e;
      rsp_stall = 1'b0;
      taken     = 0;
      rsp_calm  = 1'b0;
      forever begin
         if (taken == CHOKE_AT) hold = CHOKE_CYCLES;
         else hold = rsp_calm ? 0 : $urandom_range(0, 3);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (mixed_due.size() == 0) begin
            $error("result with nothing expected: out_slot %0d mixed_sample %0d",
                   rsp_out_slot, rsp_mixed_sample);
            errors++;
         end else begin
            e = mixed_due.pop_front();
            if (rsp_mixed_sample !== e.mixed) begin
               $error("mixed_sample: expected %0d, actual %0d",
                      $signed(e.mixed), rsp_mixed_sample);
               errors++;
            end
            if (rsp_out_slot !== e.slot) begin
               $error("out_slot: expected %0d, actual %0d", e.slot, rsp_out_slot);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d, actual %0d", e.last, rsp_last);
               errors++;
            end
         end
         taken++;
         // Re-draw the receiver's mood once per frame.
         if (taken % FRAME_SLOTS == 0) rsp_calm = ($urandom_range(0, 3) == 0);
      end
   end

   // Stop a hung run.
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
